FILE: hdl/mse_pkg.sv
// shared types, constants and helpers for the mips subset execute block
package mse_pkg;

    // storage sizes
    localparam int MEM_WORDS     = 256;
    localparam int MEM_AW        = $clog2(MEM_WORDS);
    localparam int PROGRAM_WORDS = 256;
    localparam int PC_W          = $clog2(PROGRAM_WORDS);
    localparam int RF_DEPTH      = 32;
    localparam int RF_AW         = $clog2(RF_DEPTH);

    // request modes
    localparam logic [2:0] MODE_EXEC     = 3'd0;
    localparam logic [2:0] MODE_LOAD_REG = 3'd1;
    localparam logic [2:0] MODE_LOAD_MEM = 3'd2;
    localparam logic [2:0] MODE_READ_REG = 3'd3;
    localparam logic [2:0] MODE_READ_MEM = 3'd4;

    // opcodes and function codes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] FN_ADD   = 6'b100000;
    localparam logic [5:0] FN_SUB   = 6'b100010;
    localparam logic [5:0] FN_SLT   = 6'b101010;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_RANGE       = 2'd2;

    // modeled multi-cycle counts
    localparam logic [2:0] CYC_NONE   = 3'd0;
    localparam logic [2:0] CYC_BRANCH = 3'd3;
    localparam logic [2:0] CYC_ALU    = 3'd4;
    localparam logic [2:0] CYC_LOAD   = 3'd5;

    // one accepted request
    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        instruction;
        logic [7:0]         load_index;
        logic signed [31:0] load_value;
    } in_item_t;

    // per-item state carried into the write-back stage
    typedef struct packed {
        logic [7:0]       next_pc;
        logic [1:0]       status;
        logic             reg_written;
        logic [4:0]       write_reg;
        logic [31:0]      wval;
        logic             mem_written;
        logic             rf_we;
        logic [RF_AW-1:0] rf_waddr;
        logic             from_mem;
        logic             rd_mem;
        logic [31:0]      rd_data;
        logic [2:0]       cycles;
    } stage_c_t;

    // execute stage result: write-back state plus data memory access
    typedef struct packed {
        stage_c_t          res;
        logic [PC_W-1:0]   pc_next;
        logic              mem_we;
        logic              mem_re;
        logic [MEM_AW-1:0] mem_addr;
        logic [31:0]       mem_wdata;
    } exec_t;

    // one result
    typedef struct packed {
        logic [7:0]         next_pc;
        logic [1:0]         status;
        logic               reg_written;
        logic [4:0]         write_reg;
        logic signed [31:0] write_value;
        logic               mem_written;
        logic signed [31:0] read_data;
        logic [2:0]         cycles_taken;
    } out_item_t;

    // register read port a: rs, or the index in register read mode
    function automatic logic [RF_AW-1:0] rf_addr_a(input in_item_t item);
        logic [RF_AW-1:0] addr;
        if (item.mode == MODE_READ_REG)
        begin
            addr = item.load_index[RF_AW-1:0];
        end
        else
        begin
            addr = item.instruction[25:21];
        end
        return addr;
    endfunction

endpackage

FILE: hdl/mse_channels.sv
// request and result channel interfaces of the mips subset execute block
interface mse_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [31:0]        instruction;
    logic [7:0]         load_index;
    logic signed [31:0] load_value;

    modport source (output valid, mode, instruction, load_index, load_value, input ready);
    modport sink (input valid, mode, instruction, load_index, load_value, output ready);
endinterface

interface mse_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         next_pc;
    logic [1:0]         status;
    logic               reg_written;
    logic [4:0]         write_reg;
    logic signed [31:0] write_value;
    logic               mem_written;
    logic signed [31:0] read_data;
    logic [2:0]         cycles_taken;

    modport source (output valid, next_pc, status, reg_written, write_reg, write_value,
                    mem_written, read_data, cycles_taken, input ready);
    modport sink (input valid, next_pc, status, reg_written, write_reg, write_value,
                  mem_written, read_data, cycles_taken, output ready);
endinterface

FILE: hdl/mse_regfile.sv
// register file: two registered read ports, one write port, reset via valid bits
module mse_regfile (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [mse_pkg::RF_AW-1:0] ra_addr,
    input  logic [mse_pkg::RF_AW-1:0] rb_addr,
    output logic [31:0]               ra_data,
    output logic [31:0]               rb_data,
    input  logic                      we,
    input  logic [mse_pkg::RF_AW-1:0] waddr,
    input  logic [31:0]               wdata
);

    logic [31:0]                   rf_mem_reg [mse_pkg::RF_DEPTH];
    logic [mse_pkg::RF_DEPTH-1:0]  valid_reg;
    logic                          ra_valid_reg;
    logic                          rb_valid_reg;
    logic [31:0]                   ra_q_reg;
    logic [31:0]                   rb_q_reg;
    logic                          wr_ok;

    // r0 is never written, so it always reads as zero
    assign wr_ok = we && (waddr != '0);

    // entry valid bits and read valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            ra_valid_reg <= 1'b0;
            rb_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                ra_valid_reg <= valid_reg[ra_addr];
                rb_valid_reg <= valid_reg[rb_addr];
            end
            if (wr_ok)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // storage write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            rf_mem_reg[waddr] <= wdata;
        end
        if (rd_en)
        begin
            ra_q_reg <= rf_mem_reg[ra_addr];
            rb_q_reg <= rf_mem_reg[rb_addr];
        end
    end

    // never-written entries read as zero
    assign ra_data = ra_valid_reg ? ra_q_reg : '0;
    assign rb_data = rb_valid_reg ? rb_q_reg : '0;

endmodule

FILE: hdl/mse_dmem.sv
// data memory: single port, registered read, reset via valid bits
module mse_dmem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       we,
    input  logic [mse_pkg::MEM_AW-1:0] addr,
    input  logic [31:0]                wdata,
    output logic [31:0]                rdata
);

    logic [31:0]                   dm_mem_reg [mse_pkg::MEM_WORDS];
    logic [mse_pkg::MEM_WORDS-1:0] valid_reg;
    logic                          rd_valid_reg;
    logic [31:0]                   rd_q_reg;

    // entry valid bits and read valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            else
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    // storage access
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                dm_mem_reg[addr] <= wdata;
            end
            else
            begin
                rd_q_reg <= dm_mem_reg[addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_q_reg : '0;

endmodule

FILE: hdl/mse_exec.sv
// execute stage: decode, alu, branch target, address check and mode handling
module mse_exec (
    input  mse_pkg::in_item_t           item,
    input  logic [mse_pkg::PC_W-1:0]    pc,
    input  logic [31:0]                 a,
    input  logic [31:0]                 b,
    output mse_pkg::exec_t              ex
);

    localparam int AW = mse_pkg::MEM_AW;
    localparam int PW = mse_pkg::PC_W;
    localparam int RW = mse_pkg::RF_AW;

    logic [5:0]    op;
    logic [5:0]    fn;
    logic [4:0]    rt;
    logic [4:0]    rd;
    logic [31:0]   imm;
    logic [31:0]   ea;
    logic          ea_ok;
    logic          idx_mem_ok;
    logic          idx_rf_ok;
    logic [PW-1:0] pc_inc;
    logic          taken;
    logic          wb;

    // instruction fields and shared datapath pieces
    assign op         = item.instruction[31:26];
    assign fn         = item.instruction[5:0];
    assign rt         = item.instruction[20:16];
    assign rd         = item.instruction[15:11];
    assign imm        = {{16{item.instruction[15]}}, item.instruction[15:0]};
    assign ea         = a + imm;
    assign ea_ok      = {2'b00, ea[31:2]} < 32'(mse_pkg::MEM_WORDS);
    assign idx_mem_ok = 32'(item.load_index) < 32'(mse_pkg::MEM_WORDS);
    assign idx_rf_ok  = item.load_index < 8'(mse_pkg::RF_DEPTH);
    assign pc_inc     = pc + PW'(1);
    assign taken      = (op == mse_pkg::OP_BEQ) == (a == b);

    // per-mode behavior
    always_comb
    begin
        ex         = '0;
        ex.pc_next = pc;
        wb         = 1'b0;
        case (item.mode)
            mse_pkg::MODE_EXEC:
            begin
                ex.pc_next = pc_inc;
                case (op)
                    mse_pkg::OP_RTYPE:
                    begin
                        case (fn)
                            mse_pkg::FN_ADD:
                            begin
                                ex.res.wval = a + b;
                                wb          = 1'b1;
                            end
                            mse_pkg::FN_SUB:
                            begin
                                ex.res.wval = a - b;
                                wb          = 1'b1;
                            end
                            mse_pkg::FN_SLT:
                            begin
                                ex.res.wval = {31'd0, $signed(a) < $signed(b)};
                                wb          = 1'b1;
                            end
                            default:
                            begin
                                ex.res.status = mse_pkg::ST_UNSUPPORTED;
                            end
                        endcase
                        if (wb)
                        begin
                            ex.res.write_reg = rd;
                            ex.res.cycles    = mse_pkg::CYC_ALU;
                        end
                    end
                    mse_pkg::OP_ADDI:
                    begin
                        ex.res.wval      = ea;
                        ex.res.write_reg = rt;
                        ex.res.cycles    = mse_pkg::CYC_ALU;
                        wb               = 1'b1;
                    end
                    mse_pkg::OP_BEQ, mse_pkg::OP_BNE:
                    begin
                        if (taken)
                        begin
                            ex.pc_next = pc_inc + imm[PW-1:0];
                        end
                        ex.res.cycles = mse_pkg::CYC_BRANCH;
                    end
                    mse_pkg::OP_LW, mse_pkg::OP_SW:
                    begin
                        if (!ea_ok)
                        begin
                            ex.res.status = mse_pkg::ST_RANGE;
                        end
                        else if (op == mse_pkg::OP_LW)
                        begin
                            ex.mem_re        = 1'b1;
                            ex.mem_addr      = ea[AW+1:2];
                            ex.res.from_mem  = 1'b1;
                            ex.res.write_reg = rt;
                            ex.res.cycles    = mse_pkg::CYC_LOAD;
                            wb               = 1'b1;
                        end
                        else
                        begin
                            ex.mem_we          = 1'b1;
                            ex.mem_addr        = ea[AW+1:2];
                            ex.mem_wdata       = b;
                            ex.res.wval        = b;
                            ex.res.mem_written = 1'b1;
                            ex.res.cycles      = mse_pkg::CYC_ALU;
                        end
                    end
                    default:
                    begin
                        ex.res.status = mse_pkg::ST_UNSUPPORTED;
                    end
                endcase
                // write-back to r0 is dropped but still reported
                ex.res.reg_written = wb && (ex.res.write_reg != 5'd0);
                ex.res.rf_we       = ex.res.reg_written;
                ex.res.rf_waddr    = ex.res.write_reg;
            end
            mse_pkg::MODE_LOAD_REG:
            begin
                if (idx_rf_ok && (item.load_index != 8'd0))
                begin
                    ex.res.rf_we    = 1'b1;
                    ex.res.rf_waddr = item.load_index[RW-1:0];
                    ex.res.wval     = item.load_value;
                end
            end
            mse_pkg::MODE_LOAD_MEM:
            begin
                if (idx_mem_ok)
                begin
                    ex.mem_we    = 1'b1;
                    ex.mem_addr  = AW'(item.load_index);
                    ex.mem_wdata = item.load_value;
                    ex.res.wval  = item.load_value;
                end
                else
                begin
                    ex.res.status = mse_pkg::ST_RANGE;
                end
            end
            mse_pkg::MODE_READ_REG:
            begin
                if (idx_rf_ok)
                begin
                    ex.res.rd_data = a;
                end
            end
            mse_pkg::MODE_READ_MEM:
            begin
                if (idx_mem_ok)
                begin
                    ex.mem_re     = 1'b1;
                    ex.mem_addr   = AW'(item.load_index);
                    ex.res.rd_mem = 1'b1;
                end
                else
                begin
                    ex.res.status = mse_pkg::ST_RANGE;
                end
            end
            default:
            begin
                ex.res.status = mse_pkg::ST_OK;
            end
        endcase
        ex.res.next_pc = 8'(ex.pc_next);
    end

endmodule

FILE: hdl/mips_subset_execute.sv
// mips subset execute block: register read, execute, memory/write-back, result register
// throughput: one request per cycle; a stalled result holds the whole three-stage pipeline
// register-file reads are registered at acceptance, data memory is accessed at most once per item
// reset clears the pc, the pipeline valids and the valid bits of both storage arrays
// storage reads as zero after reset without any clearing pass, requests taken at once
module mips_subset_execute (
    input logic       clk,
    input logic       rst_n,
    mse_req_if.sink   req,
    mse_rsp_if.source rsp
);

    localparam int RW = mse_pkg::RF_AW;
    localparam int AW = mse_pkg::MEM_AW;

    logic                         advance;
    mse_pkg::in_item_t            req_item;
    logic                         b_valid_reg;
    mse_pkg::in_item_t            b_item_reg;
    logic                         c_valid_reg;
    mse_pkg::stage_c_t            c_reg;
    logic                         out_valid_reg;
    mse_pkg::out_item_t           out_reg;
    mse_pkg::out_item_t           out_next;
    logic [mse_pkg::PC_W-1:0]     pc_reg;
    logic                         lw_valid_reg;
    logic [RW-1:0]                lw_addr_reg;
    logic [31:0]                  lw_data_reg;
    logic [31:0]                  rf_a;
    logic [31:0]                  rf_b;
    logic [31:0]                  fwd_a;
    logic [31:0]                  fwd_b;
    logic [RW-1:0]                b_ra;
    logic [RW-1:0]                b_rb;
    logic [31:0]                  dm_rdata;
    logic [31:0]                  c_wdata;
    logic                         dm_en;
    mse_pkg::exec_t               ex;

    // whole pipeline moves when the result register is free or being taken
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    assign req_item.mode        = req.mode;
    assign req_item.instruction = req.instruction;
    assign req_item.load_index  = req.load_index;
    assign req_item.load_value  = req.load_value;

    // register file, read at acceptance
    mse_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .ra_addr (mse_pkg::rf_addr_a(req_item)),
        .rb_addr (req_item.instruction[20:16]),
        .ra_data (rf_a),
        .rb_data (rf_b),
        .we      (advance && c_valid_reg && c_reg.rf_we),
        .waddr   (c_reg.rf_waddr),
        .wdata   (c_wdata)
    );

    // value written back by the item in the last stage
    assign c_wdata = c_reg.from_mem ? dm_rdata : c_reg.wval;

    // bypass from the write-back stage and from the write retired at the read edge
    assign b_ra = mse_pkg::rf_addr_a(b_item_reg);
    assign b_rb = b_item_reg.instruction[20:16];

    always_comb
    begin
        if (c_valid_reg && c_reg.rf_we && (c_reg.rf_waddr == b_ra))
        begin
            fwd_a = c_wdata;
        end
        else if (lw_valid_reg && (lw_addr_reg == b_ra))
        begin
            fwd_a = lw_data_reg;
        end
        else
        begin
            fwd_a = rf_a;
        end
        if (c_valid_reg && c_reg.rf_we && (c_reg.rf_waddr == b_rb))
        begin
            fwd_b = c_wdata;
        end
        else if (lw_valid_reg && (lw_addr_reg == b_rb))
        begin
            fwd_b = lw_data_reg;
        end
        else
        begin
            fwd_b = rf_b;
        end
    end

    // execute
    mse_exec u_exec (
        .item (b_item_reg),
        .pc   (pc_reg),
        .a    (fwd_a),
        .b    (fwd_b),
        .ex   (ex)
    );

    // data memory, accessed as the item leaves execute
    assign dm_en = advance && b_valid_reg && (ex.mem_we || ex.mem_re);

    mse_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (dm_en),
        .we    (ex.mem_we),
        .addr  (ex.mem_addr[AW-1:0]),
        .wdata (ex.mem_wdata),
        .rdata (dm_rdata)
    );

    // result assembly
    always_comb
    begin
        out_next.next_pc      = c_reg.next_pc;
        out_next.status       = c_reg.status;
        out_next.reg_written  = c_reg.reg_written;
        out_next.write_reg    = c_reg.write_reg;
        out_next.write_value  = c_wdata;
        out_next.mem_written  = c_reg.mem_written;
        out_next.read_data    = c_reg.rd_mem ? dm_rdata : c_reg.rd_data;
        out_next.cycles_taken = c_reg.cycles;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            pc_reg        <= '0;
        end
        else if (advance)
        begin
            b_valid_reg   <= req.valid;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
            lw_valid_reg  <= c_valid_reg && c_reg.rf_we;
            if (b_valid_reg)
            begin
                pc_reg <= ex.pc_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg  <= req_item;
            c_reg       <= ex.res;
            out_reg     <= out_next;
            lw_addr_reg <= c_reg.rf_waddr;
            lw_data_reg <= c_wdata;
        end
    end

    // result channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.next_pc      = out_reg.next_pc;
    assign rsp.status       = out_reg.status;
    assign rsp.reg_written  = out_reg.reg_written;
    assign rsp.write_reg    = out_reg.write_reg;
    assign rsp.write_value  = out_reg.write_value;
    assign rsp.mem_written  = out_reg.mem_written;
    assign rsp.read_data    = out_reg.read_data;
    assign rsp.cycles_taken = out_reg.cycles_taken;

endmodule

FILE: verif/tb_mips_subset_execute.sv
// testbench for the mips subset execute block: directed and random requests checked against a model
module tb_mips_subset_execute;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PERCENT   = 25;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // encodings the block does not support
    localparam logic [5:0] OP_UNKNOWN       = 6'h3F;
    localparam logic [5:0] FN_UNKNOWN       = 6'h00;
    localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
    localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    mse_req_if req ();
    mse_rsp_if rsp ();

    mips_subset_execute i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // architectural state as the block should hold it
    logic [31:0] arch_regs [mse_pkg::RF_DEPTH];
    logic [31:0] arch_mem [mse_pkg::MEM_WORDS];
    logic [7:0]  arch_pc;

    mse_pkg::out_item_t pending_outcomes [$];
    int                 mismatch_count = 0;
    int                 stall_cycles   = 0;
    logic               no_gaps        = 1'b0;
    logic               hold_results   = 1'b0;

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // instruction encoders
    function automatic logic [31:0] encode_r(input logic [5:0] fn, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [4:0] rd);
        return {mse_pkg::OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] encode_i(input logic [5:0] op, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // runs one request on the architectural state and returns its outcome
    function automatic mse_pkg::out_item_t predict_execution(input mse_pkg::in_item_t it);
        mse_pkg::out_item_t res;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  dest;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [31:0] value;
        logic        wb;
        logic [7:0]  npc;
        res   = '0;
        wb    = 1'b0;
        dest  = '0;
        value = '0;
        npc   = arch_pc;
        op    = it.instruction[31:26];
        rs    = it.instruction[25:21];
        rt    = it.instruction[20:16];
        rd    = it.instruction[15:11];
        fn    = it.instruction[5:0];
        imm   = {{16{it.instruction[15]}}, it.instruction[15:0]};
        a     = arch_regs[rs];
        b     = arch_regs[rt];
        addr  = a + imm;
        case (it.mode)
            mse_pkg::MODE_EXEC:
            begin
                npc = arch_pc + 8'd1;
                case (op)
                    mse_pkg::OP_RTYPE:
                    begin
                        wb = 1'b1;
                        dest = rd;
                        res.cycles_taken = mse_pkg::CYC_ALU;
                        case (fn)
                            mse_pkg::FN_ADD: value = a + b;
                            mse_pkg::FN_SUB: value = a - b;
                            mse_pkg::FN_SLT: value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            default:
                            begin
                                wb = 1'b0;
                                res.cycles_taken = mse_pkg::CYC_NONE;
                                res.status = mse_pkg::ST_UNSUPPORTED;
                            end
                        endcase
                    end
                    mse_pkg::OP_ADDI:
                    begin
                        wb = 1'b1;
                        dest = rt;
                        value = a + imm;
                        res.cycles_taken = mse_pkg::CYC_ALU;
                    end
                    mse_pkg::OP_BEQ, mse_pkg::OP_BNE:
                    begin
                        // taken branch is relative to pc+1, wraps in 8 bits
                        if ((op == mse_pkg::OP_BEQ) == (a == b))
                        begin
                            npc = npc + imm[7:0];
                        end
                        res.cycles_taken = mse_pkg::CYC_BRANCH;
                    end
                    mse_pkg::OP_LW, mse_pkg::OP_SW:
                    begin
                        if ((addr >> 2) >= 32'(mse_pkg::MEM_WORDS))
                        begin
                            res.status = mse_pkg::ST_RANGE;
                        end
                        else if (op == mse_pkg::OP_LW)
                        begin
                            wb = 1'b1;
                            dest = rt;
                            value = arch_mem[addr[mse_pkg::MEM_AW+1:2]];
                            res.cycles_taken = mse_pkg::CYC_LOAD;
                        end
                        else
                        begin
                            arch_mem[addr[mse_pkg::MEM_AW+1:2]] = b;
                            res.write_value = b;
                            res.mem_written = 1'b1;
                            res.cycles_taken = mse_pkg::CYC_ALU;
                        end
                    end
                    default: res.status = mse_pkg::ST_UNSUPPORTED;
                endcase
                // write-back, r0 shows the value but keeps zero
                if (wb)
                begin
                    res.write_reg = dest;
                    res.write_value = value;
                    if (dest != 5'd0)
                    begin
                        arch_regs[dest] = value;
                        res.reg_written = 1'b1;
                    end
                end
                arch_pc = npc;
            end
            mse_pkg::MODE_LOAD_REG:
            begin
                if (it.load_index < mse_pkg::RF_DEPTH && it.load_index != 8'd0)
                begin
                    arch_regs[it.load_index[mse_pkg::RF_AW-1:0]] = it.load_value;
                    res.write_value = it.load_value;
                end
            end
            mse_pkg::MODE_LOAD_MEM:
            begin
                if (it.load_index < mse_pkg::MEM_WORDS)
                begin
                    arch_mem[it.load_index] = it.load_value;
                    res.write_value = it.load_value;
                end
                else
                begin
                    res.status = mse_pkg::ST_RANGE;
                end
            end
            mse_pkg::MODE_READ_REG:
            begin
                if (it.load_index < mse_pkg::RF_DEPTH)
                begin
                    res.read_data = arch_regs[it.load_index[mse_pkg::RF_AW-1:0]];
                end
            end
            mse_pkg::MODE_READ_MEM:
            begin
                if (it.load_index < mse_pkg::MEM_WORDS)
                begin
                    res.read_data = arch_mem[it.load_index];
                end
                else
                begin
                    res.status = mse_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
        res.next_pc = npc;
        return res;
    endfunction

    // random request: mostly well-formed instructions, some loads, reads and noise
    function automatic mse_pkg::in_item_t random_request();
        mse_pkg::in_item_t it;
        int          pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] imm;
        it.mode        = mse_pkg::MODE_EXEC;
        it.instruction = $urandom;
        it.load_index  = 8'($urandom);
        it.load_value  = $urandom;
        rs   = 5'($urandom_range(0, 31));
        rt   = 5'($urandom_range(0, 31));
        rd   = 5'($urandom_range(0, 31));
        imm  = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it.mode = mse_pkg::MODE_LOAD_REG;
            it.load_index = 8'($urandom_range(0, 39));
            // small values keep many later addresses in range
            if ($urandom_range(0, 1) == 0)
            begin
                it.load_value = $urandom_range(0, 1100);
            end
        end
        else if (pick < 13)
        begin
            it.mode = mse_pkg::MODE_LOAD_MEM;
        end
        else if (pick < 17)
        begin
            it.mode = mse_pkg::MODE_READ_REG;
            if ($urandom_range(0, 3) != 0)
            begin
                it.load_index = 8'($urandom_range(0, 31));
            end
        end
        else if (pick < 21)
        begin
            it.mode = mse_pkg::MODE_READ_MEM;
        end
        else if (pick < 23)
        begin
            it.mode = 3'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI));
        end
        else if (pick >= 28)
        begin
            case ($urandom_range(0, 7))
                0: it.instruction = encode_r(mse_pkg::FN_ADD, rs, rt, rd);
                1: it.instruction = encode_r(mse_pkg::FN_SUB, rs, rt, rd);
                2: it.instruction = encode_r(mse_pkg::FN_SLT, rs, rt, rd);
                3: it.instruction = encode_i(mse_pkg::OP_ADDI, rs, rt, imm);
                4, 5:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        rt = rs;
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        imm = 16'($urandom_range(0, 16)) - 16'd8;
                    end
                    it.instruction = encode_i(($urandom_range(0, 1) == 0) ?
                                              mse_pkg::OP_BEQ : mse_pkg::OP_BNE,
                                              rs, rt, imm);
                end
                default:
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        rs = 5'd0;
                    end
                    if ($urandom_range(0, 7) != 0)
                    begin
                        imm = 16'($urandom_range(0, 1100));
                    end
                    it.instruction = encode_i(($urandom_range(0, 1) == 0) ?
                                              mse_pkg::OP_LW : mse_pkg::OP_SW,
                                              rs, rt, imm);
                end
            endcase
        end
        // otherwise keep the fully random instruction word as noise
        return it;
    endfunction

    // offers one request, with random gaps before it, and records its outcome on acceptance
    task automatic send_request(input mse_pkg::in_item_t it);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= it.mode;
        req.instruction <= it.instruction;
        req.load_index  <= it.load_index;
        req.load_value  <= it.load_value;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        pending_outcomes.push_back(predict_execution(it));
        @(negedge clk);
    endtask

    task automatic send_exec(input logic [31:0] insn);
        mse_pkg::in_item_t it;
        it.mode        = mse_pkg::MODE_EXEC;
        it.instruction = insn;
        it.load_index  = 8'($urandom);
        it.load_value  = $urandom;
        send_request(it);
    endtask

    task automatic send_access(input logic [2:0] mode, input logic [7:0] index,
                               input logic [31:0] value);
        mse_pkg::in_item_t it;
        it.mode        = mode;
        it.instruction = $urandom;
        it.load_index  = index;
        it.load_value  = value;
        send_request(it);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    endtask

    // field extremes, every operation and the special cases
    task automatic test_directed_cases();
        send_access(mse_pkg::MODE_LOAD_REG, 8'd1, 32'h7FFF_FFFF);
        send_access(mse_pkg::MODE_LOAD_REG, 8'd2, 32'h8000_0000);
        send_access(mse_pkg::MODE_LOAD_REG, 8'd3, 32'hFFFF_FFFF);
        // r0 load and a register number past the file are ignored
        send_access(mse_pkg::MODE_LOAD_REG, 8'd0, 32'h1234_5678);
        send_access(mse_pkg::MODE_LOAD_REG, 8'd255, 32'h5A5A_5A5A);
        send_access(mse_pkg::MODE_READ_REG, 8'd0, 32'd0);
        send_access(mse_pkg::MODE_READ_REG, 8'd200, 32'd0);
        send_access(mse_pkg::MODE_LOAD_MEM, 8'd255, 32'hDEAD_BEEF);
        send_access(mse_pkg::MODE_READ_MEM, 8'd255, 32'd0);
        // alu: wrap-around, signed compare, r0 destination
        send_exec(encode_r(mse_pkg::FN_ADD, 5'd1, 5'd1, 5'd4));
        send_exec(encode_r(mse_pkg::FN_SUB, 5'd2, 5'd1, 5'd5));
        send_exec(encode_r(mse_pkg::FN_SLT, 5'd2, 5'd1, 5'd6));
        send_exec(encode_r(mse_pkg::FN_SLT, 5'd1, 5'd3, 5'd7));
        send_exec(encode_r(mse_pkg::FN_ADD, 5'd1, 5'd3, 5'd0));
        send_exec(encode_i(mse_pkg::OP_ADDI, 5'd0, 5'd8, 16'h8000));
        send_exec(encode_i(mse_pkg::OP_ADDI, 5'd3, 5'd9, 16'h7FFF));
        // memory: last word, ignored low address bits, out of range
        send_exec(encode_i(mse_pkg::OP_SW, 5'd0, 5'd1, 16'd1020));
        send_exec(encode_i(mse_pkg::OP_LW, 5'd0, 5'd10, 16'd1023));
        send_exec(encode_i(mse_pkg::OP_LW, 5'd0, 5'd11, 16'd1024));
        send_exec(encode_i(mse_pkg::OP_SW, 5'd2, 5'd1, 16'hFFFC));
        // unsupported opcode and function
        send_exec(encode_i(OP_UNKNOWN, 5'd31, 5'd31, 16'hFFFF));
        send_exec(encode_r(FN_UNKNOWN, 5'd1, 5'd2, 5'd12));
        // branches taken and not taken, offsets at the field extremes
        send_exec(encode_i(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
        send_exec(encode_i(mse_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0010));
        send_exec(encode_i(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'h7FFF));
        send_exec(encode_i(mse_pkg::OP_BNE, 5'd0, 5'd0, 16'h0003));
        // reserved modes
        send_access(MODE_RESERVED_LO, 8'd7, 32'hFFFF_FFFF);
        send_access(MODE_RESERVED_HI, 8'd9, 32'h0000_0001);
    endtask

    task automatic test_random_program(input int count);
        repeat (count)
        begin
            send_request(random_request());
        end
    endtask

    // results held back long enough for the pipeline to fill and stall requests
    task automatic test_result_backpressure();
        hold_results = 1'b1;
        repeat (40)
        begin
            send_request(random_request());
        end
        wait (!hold_results);
    endtask

    task automatic test_unbroken_stream();
        no_gaps = 1'b1;
        repeat (80)
        begin
            send_request(random_request());
        end
        no_gaps = 1'b0;
    endtask

    // result receiver: random stalls, or a counted hold when asked
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(negedge clk);
                end
                hold_results = 1'b0;
            end
            else
            begin
                rsp.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // result check against the oldest outcome
    always @(posedge clk)
    begin : check_results
        mse_pkg::out_item_t got;
        mse_pkg::out_item_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.next_pc      = rsp.next_pc;
            got.status       = rsp.status;
            got.reg_written  = rsp.reg_written;
            got.write_reg    = rsp.write_reg;
            got.write_value  = rsp.write_value;
            got.mem_written  = rsp.mem_written;
            got.read_data    = rsp.read_data;
            got.cycles_taken = rsp.cycles_taken;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result with none outstanding", 32'(got.next_pc), 32'd0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.reg_written !== want.reg_written)
                    report_mismatch("reg_written", 32'(got.reg_written),
                                    32'(want.reg_written));
                if (got.write_reg !== want.write_reg)
                    report_mismatch("write_reg", 32'(got.write_reg), 32'(want.write_reg));
                if (got.write_value !== want.write_value)
                    report_mismatch("write_value", got.write_value, want.write_value);
                if (got.mem_written !== want.mem_written)
                    report_mismatch("mem_written", 32'(got.mem_written),
                                    32'(want.mem_written));
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.cycles_taken !== want.cycles_taken)
                    report_mismatch("cycles_taken", 32'(got.cycles_taken),
                                    32'(want.cycles_taken));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // reset, stimulus and end of run
    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.mode        = mse_pkg::MODE_EXEC;
        req.instruction = '0;
        req.load_index  = '0;
        req.load_value  = '0;
        arch_pc         = '0;
        for (int i = 0; i < mse_pkg::RF_DEPTH; i++)
        begin
            arch_regs[i] = '0;
        end
        for (int i = 0; i < mse_pkg::MEM_WORDS; i++)
        begin
            arch_mem[i] = '0;
        end
        repeat (RESET_CYCLES)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_program(450);
        test_result_backpressure();
        test_unbroken_stream();
        test_random_program(460);

        req.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
